>>> rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the skeleton world matrix evaluator.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int JOINT_CAP = 64;
    localparam int FRAC_BITS = 16;

    localparam int WORD_W  = 32;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int JOINT_W = $clog2(JOINT_CAP);
    localparam int JCNT_W  = $clog2(JOINT_CAP + 1);
    localparam int LIMIT_W = 7;
    localparam int ROWS    = 4;
    localparam int COL_W   = 2;

    localparam int PAL_DEPTH = JOINT_CAP * ROWS;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int PAL_W     = ROWS * WORD_W;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_PARENT = 2'd1,
        ERR_LIMIT  = 2'd2
    } err_t;

    // Tag that travels with each request column step through the pipeline
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic               has_parent;
        logic               ok;
        logic [JOINT_W-1:0] joint;
        logic [COL_W-1:0]   col;
        err_t               status;
        logic               done;
    } tag_t;

endpackage
`default_nettype wire

>>> rtl/skeleton_world_matrix_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skeleton_world_matrix_eval
// World matrix columns for a skeleton sent parent before child.
// ----------------------------------------------------------------------------
// Each request is one column of a joint's local 4x4 matrix (Q16.16). The
// block answers with the same column of the joint's world matrix: the
// parent's world matrix from the palette times the local column, or the
// local column itself for a root. For each request a row of four 32x32
// multipliers walks the parent's four columns, one per cycle while the
// output does not stall, through the single read port of the palette RAM
// (256 words of 128 bits, one column a word). A request whose parent
// columns are still on their way to the palette waits until the write has
// landed, so a child of the joint just sent may be held back. The palette
// needs no clearing pass after reset. Errors (parent not earlier, joint
// limit exceeded) give zero data and hold until the skeleton ends on
// column 3 of a last_joint request.
module skeleton_world_matrix_eval (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [swm_pkg::LIMIT_W-1:0]     cfg_wr_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            has_parent,
    input  wire logic [swm_pkg::JOINT_W-1:0]     parent_index,
    input  wire logic signed [swm_pkg::WORD_W-1:0] elem_row0,
    input  wire logic signed [swm_pkg::WORD_W-1:0] elem_row1,
    input  wire logic signed [swm_pkg::WORD_W-1:0] elem_row2,
    input  wire logic signed [swm_pkg::WORD_W-1:0] elem_row3,
    input  wire logic                            last_joint,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [swm_pkg::JOINT_W-1:0]          joint_number,
    output logic [swm_pkg::COL_W-1:0]            column_number,
    output logic signed [swm_pkg::WORD_W-1:0]    world_row0,
    output logic signed [swm_pkg::WORD_W-1:0]    world_row1,
    output logic signed [swm_pkg::WORD_W-1:0]    world_row2,
    output logic signed [swm_pkg::WORD_W-1:0]    world_row3,
    output logic [1:0]                           status,
    output logic                                 skeleton_done
);
    import swm_pkg::*;

    // Configuration and sequencing state
    logic [LIMIT_W-1:0] limit_reg;
    logic [JCNT_W-1:0]  jcnt_reg, jcnt_next;
    logic [COL_W-1:0]   ccnt_reg, ccnt_next;
    err_t               err_reg, err_next;

    // Issue stage: the request whose parent columns are being read
    tag_t               iss_reg;
    logic [COL_W-1:0]   k_reg;
    logic [JOINT_W-1:0] par_reg;
    word_t              loc_reg [ROWS];

    // Read data stage
    tag_t               s1_reg, s1_next;
    word_t              lk_reg;

    // Output register
    logic               out_valid_reg;
    tag_t               out_tag_reg;
    word_t              out_world_reg [ROWS];

    tag_t               s2_tag, s3_tag;
    word_t              fin_world [ROWS];
    word_t              pcol [ROWS];
    word_t              loc_in [ROWS];
    logic [PAL_W-1:0]   ram_rdata, ram_wdata;
    logic               ram_re, ram_we;
    logic [PAL_AW-1:0]  ram_raddr, ram_waddr;

    logic               fin_valid, fin_take, stall, en;
    logic               hazard, accept;
    logic [LIMIT_W-1:0] limit_eff;
    tag_t               new_tag;

    assign loc_in[0] = elem_row0;
    assign loc_in[1] = elem_row1;
    assign loc_in[2] = elem_row2;
    assign loc_in[3] = elem_row3;

    // Hold the pipeline when a finished result cannot move to the output
    assign fin_valid = s3_tag.valid && s3_tag.last;
    assign fin_take  = fin_valid && (!out_valid_reg || out_ready);
    assign stall     = fin_valid && !fin_take;
    assign en        = !stall;

    // Interlock: the parent must not have a column still on its way to the palette
    function automatic logic pending(input tag_t t, input logic [JOINT_W-1:0] j);
        return t.valid && t.ok && (t.joint == j);
    endfunction

    assign hazard = has_parent && (pending(iss_reg, parent_index) ||
                                   pending(s1_reg, parent_index) ||
                                   pending(s2_tag, parent_index) ||
                                   pending(s3_tag, parent_index));

    assign in_ready = en && (!iss_reg.valid || k_reg == COL_W'(ROWS - 1)) && !hazard;
    assign accept   = in_valid && in_ready;

    // Limit in force is the smaller of the register and the palette size
    assign limit_eff = (32'(limit_reg) > JOINT_CAP) ? LIMIT_W'(JOINT_CAP) : limit_reg;

    always_comb
    begin
        err_next = err_reg;
        if (err_reg == ERR_NONE)
        begin
            if (32'(jcnt_reg) >= 32'(limit_eff))
                err_next = ERR_LIMIT;
            else if (has_parent && (32'(parent_index) >= 32'(jcnt_reg)))
                err_next = ERR_PARENT;
        end

        new_tag            = '0;
        new_tag.valid      = 1'b1;
        new_tag.first      = 1'b1;
        new_tag.has_parent = has_parent;
        new_tag.ok         = (err_next == ERR_NONE);
        new_tag.joint      = jcnt_reg[JOINT_W-1:0];
        new_tag.col        = ccnt_reg;
        new_tag.status     = err_next;
        new_tag.done       = (ccnt_reg == COL_W'(ROWS - 1)) && last_joint;

        jcnt_next = jcnt_reg;
        ccnt_next = ccnt_reg + COL_W'(1);
        if (ccnt_reg == COL_W'(ROWS - 1))
        begin
            if (last_joint)
            begin
                jcnt_next = '0;
                err_next  = ERR_NONE;
            end
            else if (32'(jcnt_reg) < JOINT_CAP)
            begin
                jcnt_next = jcnt_reg + JCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_W'(64);
            jcnt_reg  <= '0;
            ccnt_reg  <= '0;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (accept)
            begin
                jcnt_reg <= jcnt_next;
                ccnt_reg <= ccnt_next;
                err_reg  <= err_next;
            end
        end
    end

    // Issue stage: advance k once a cycle while not stalled, take a new request on the fourth step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg <= '0;
            k_reg   <= '0;
        end
        else if (en)
        begin
            if (accept)
            begin
                iss_reg <= new_tag;
                k_reg   <= '0;
            end
            else if (iss_reg.valid)
            begin
                if (k_reg == COL_W'(ROWS - 1))
                    iss_reg.valid <= 1'b0;
                k_reg <= k_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && accept)
        begin
            par_reg <= parent_index;
            loc_reg <= loc_in;
        end
    end

    // Palette read: column k of the parent
    assign ram_re    = en && iss_reg.valid && iss_reg.has_parent;
    assign ram_raddr = {par_reg, k_reg};

    // Mark the first and last step of the walk over the parent's columns
    always_comb
    begin
        s1_next       = iss_reg;
        s1_next.first = (k_reg == '0);
        s1_next.last  = (k_reg == COL_W'(ROWS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lk_reg <= loc_reg[k_reg];
    end

    // A root multiplies by the identity: select unit column k in place of the palette
    logic [COL_W-1:0] k1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            k1_reg <= k_reg;
    end

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            if (s1_reg.has_parent)
                pcol[r] = ram_rdata[r*WORD_W +: WORD_W];
            else
                pcol[r] = (k1_reg == COL_W'(r)) ? word_t'(1 << FRAC_BITS) : '0;
        end
    end

    swm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .s1_tag (s1_reg),
        .pcol   (pcol),
        .lk     (lk_reg),
        .s2_tag (s2_tag),
        .s3_tag (s3_tag),
        .world  (fin_world)
    );

    // Write each error-free finished column back to the palette as it leaves
    assign ram_we    = fin_take && s3_tag.ok;
    assign ram_waddr = {s3_tag.joint, s3_tag.col};
    assign ram_wdata = {fin_world[3], fin_world[2], fin_world[1], fin_world[0]};

    swm_ram #(
        .WIDTH (PAL_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_take)
        begin
            out_tag_reg   <= s3_tag;
            out_world_reg <= fin_world;
        end
    end

    assign out_valid     = out_valid_reg;
    assign joint_number  = out_tag_reg.joint;
    assign column_number = out_tag_reg.col;
    assign world_row0    = out_world_reg[0];
    assign world_row1    = out_world_reg[1];
    assign world_row2    = out_world_reg[2];
    assign world_row3    = out_world_reg[3];
    assign status        = out_tag_reg.status;
    assign skeleton_done = out_tag_reg.done;

    // Checks
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("palette read and write hit the same column");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ERR_NONE |->
            world_row0 == '0 && world_row1 == '0 && world_row2 == '0 && world_row3 == '0)
        else $error("error result carries data");

    a_done_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && skeleton_done |-> column_number == COL_W'(ROWS - 1))
        else $error("skeleton end off the last column");

    a_jcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(jcnt_reg) <= JOINT_CAP)
        else $error("joint counter beyond palette");

endmodule
`default_nettype wire

>>> rtl/swm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/swm_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_mac
// Four-multiplier row with accumulators, floor shift and saturation.
// ----------------------------------------------------------------------------
module swm_mac (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire swm_pkg::tag_t  s1_tag,
    input  wire swm_pkg::word_t pcol [swm_pkg::ROWS],
    input  wire swm_pkg::word_t lk,
    output swm_pkg::tag_t       s2_tag,
    output swm_pkg::tag_t       s3_tag,
    output swm_pkg::word_t      world [swm_pkg::ROWS]
);
    import swm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [ROWS];
    logic signed [ACC_W-1:0]  acc_reg  [ROWS];
    tag_t                     tag2_reg;
    tag_t                     tag3_reg;

    function automatic word_t floor_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] sh;
        word_t                   res;
        sh = a >>> FRAC_BITS;
        if (sh > ACC_W'(signed'({1'b0, {(WORD_W-1){1'b1}}})))
            res = {1'b0, {(WORD_W-1){1'b1}}};
        else if (sh < -(ACC_W'(signed'({1'b0, {(WORD_W-1){1'b1}}}))) - ACC_W'(1))
            res = {1'b1, {(WORD_W-1){1'b0}}};
        else
            res = sh[WORD_W-1:0];
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (en)
        begin
            tag2_reg <= s1_tag;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                prod_reg[r] <= pcol[r] * lk;
                if (tag2_reg.valid)
                begin
                    acc_reg[r] <= tag2_reg.first ? ACC_W'(prod_reg[r])
                                                 : acc_reg[r] + ACC_W'(prod_reg[r]);
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            world[r] = tag3_reg.ok ? floor_sat(acc_reg[r]) : '0;
        end
    end

    assign s2_tag = tag2_reg;
    assign s3_tag = tag3_reg;

endmodule
`default_nettype wire

>>> tb/skeleton_world_matrix_eval_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_world_matrix_eval_tb
// Self-checking bench for the skeleton world matrix evaluator.
// ----------------------------------------------------------------------------
// Streams whole skeletons, one local matrix column per request, through the
// block. A scoreboard object keeps its own palette, joint/column counters and
// error state, predicts every world column in Q16.16 (floor shift, saturation)
// and checks results in order. The run covers directed corner requests, then
// random skeletons under several joint limits (1, 0, 127, small, 64, random).
// The sender idles in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module skeleton_world_matrix_eval_tb;
    import swm_pkg::*;

    typedef struct {
        logic [JOINT_W-1:0] joint;
        logic [COL_W-1:0]   col;
        word_t              row [4];
        err_t               status;
        logic               done;
    } world_col_t;

    // Scoreboard: shadow state of the block plus the queue of pending columns
    class world_scoreboard;
        word_t      palette [JOINT_CAP*16];
        int         joint_cnt;
        int         col_cnt;
        int         err_code;
        int         limit_reg;
        world_col_t pending [$];
        int         mismatches;
        int         checked;
        int         parent_errs;
        int         limit_errs;
        int         skeletons;

        function new();
            foreach (palette[i]) palette[i] = '0;
            joint_cnt = 0;
            col_cnt   = 0;
            err_code  = ERR_NONE;
            limit_reg = 64;
        endfunction

        function void set_limit(int v);
            limit_reg = v;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Work out the world column for one accepted request
        function void note_request(logic hp, logic [JOINT_W-1:0] pidx,
                                   word_t l0, word_t l1, word_t l2, word_t l3,
                                   logic last);
            longint     loc [4];
            longint     hi, lo, p, h;
            int         lim;
            world_col_t res;
            loc[0] = l0; loc[1] = l1; loc[2] = l2; loc[3] = l3;
            lim = (limit_reg < JOINT_CAP) ? limit_reg : JOINT_CAP;
            for (int r = 0; r < 4; r++) res.row[r] = '0;
            if (err_code == ERR_NONE) begin
                if (joint_cnt >= lim) err_code = ERR_LIMIT;
                else if (hp && int'(pidx) >= joint_cnt) err_code = ERR_PARENT;
            end
            if (err_code == ERR_NONE) begin
                for (int r = 0; r < 4; r++) begin
                    if (!hp) res.row[r] = word_t'(loc[r]);
                    else begin
                        hi = 0;
                        lo = 0;
                        for (int k = 0; k < 4; k++) begin
                            p  = longint'(palette[int'(pidx)*16 + k*4 + r]) * loc[k];
                            h  = p >>> FRAC_BITS;
                            hi += h;
                            lo += p - (h <<< FRAC_BITS);
                        end
                        res.row[r] = word_t'(clamp32(hi + (lo >>> FRAC_BITS)));
                    end
                end
                for (int r = 0; r < 4; r++)
                    palette[(joint_cnt*16 + col_cnt*4 + r) % (JOINT_CAP*16)] = res.row[r];
            end
            res.joint  = joint_cnt[JOINT_W-1:0];
            res.col    = col_cnt[COL_W-1:0];
            res.status = err_t'(err_code);
            res.done   = (col_cnt == 3) && last;
            if (err_code == ERR_PARENT) parent_errs++;
            if (err_code == ERR_LIMIT) limit_errs++;
            pending.push_back(res);
            if (col_cnt == 3) begin
                if (last) begin
                    joint_cnt = 0;
                    err_code  = ERR_NONE;
                    skeletons++;
                end else if (joint_cnt < JOINT_CAP) joint_cnt++;
                col_cnt = 0;
            end else col_cnt++;
        endfunction

        function void check_result(world_col_t got);
            world_col_t exp_col;
            bit         bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending (joint %0d col %0d)",
                             got.joint, got.col);
                return;
            end
            exp_col = pending.pop_front();
            checked++;
            bad = (got.joint !== exp_col.joint) || (got.col !== exp_col.col) ||
                  (got.status !== exp_col.status) || (got.done !== exp_col.done);
            for (int r = 0; r < 4; r++) if (got.row[r] !== exp_col.row[r]) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp j%0d c%0d st%0d d%0d %h %h %h %h / got j%0d c%0d st%0d d%0d %h %h %h %h",
                             exp_col.joint, exp_col.col, exp_col.status, exp_col.done,
                             exp_col.row[0], exp_col.row[1], exp_col.row[2], exp_col.row[3],
                             got.joint, got.col, got.status, got.done,
                             got.row[0], got.row[1], got.row[2], got.row[3]);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    logic has_parent;
    logic [JOINT_W-1:0] parent_index;
    word_t elem_row0, elem_row1, elem_row2, elem_row3;
    logic last_joint;
    logic out_valid;
    logic out_ready;
    logic [JOINT_W-1:0] joint_number;
    logic [COL_W-1:0] column_number;
    word_t world_row0, world_row1, world_row2, world_row3;
    logic [1:0] status;
    logic skeleton_done;

    world_scoreboard sb;
    int requests_sent;
    int burst_left;
    int stall_mode;
    int stall_left;

    skeleton_world_matrix_eval uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .has_parent(has_parent), .parent_index(parent_index),
        .elem_row0(elem_row0), .elem_row1(elem_row1),
        .elem_row2(elem_row2), .elem_row3(elem_row3),
        .last_joint(last_joint),
        .out_valid(out_valid), .out_ready(out_ready),
        .joint_number(joint_number), .column_number(column_number),
        .world_row0(world_row0), .world_row1(world_row1),
        .world_row2(world_row2), .world_row3(world_row3),
        .status(status), .skeleton_done(skeleton_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both handshakes are sampled at the edge, before the bench's own
    // nonblocking updates land, so the values seen are the accepted ones.
    always @(posedge clk)
    begin
        world_col_t got;
        if (rst_n && out_valid && out_ready) begin
            got.joint  = joint_number;
            got.col    = column_number;
            got.row[0] = world_row0;
            got.row[1] = world_row1;
            got.row[2] = world_row2;
            got.row[3] = world_row3;
            got.status = err_t'(status);
            got.done   = skeleton_done;
            sb.check_result(got);
        end
        if (rst_n && in_valid && in_ready)
            sb.note_request(has_parent, parent_index, elem_row0, elem_row1,
                            elem_row2, elem_row3, last_joint);
    end

    // Receiver: change stall behaviour every so often, with free-flowing
    // stretches, coin-toss stalls and long holds.
    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end else stall_left--;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Pick one local element: mostly modest values, some full-range and extremes
    function automatic word_t pick_elem();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return word_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        if (sel < 7) return word_t'($urandom);
        if (sel == 7) return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        if (sel == 8) return ($urandom_range(0, 1)) ? 32'sh0001_0000 : 32'sh0000_0000;
        return word_t'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endfunction

    // Present one request and hold it until accepted; valid stays high after
    task automatic send_request(logic hp, logic [JOINT_W-1:0] pidx,
                                word_t l0, word_t l1, word_t l2, word_t l3,
                                logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        has_parent   <= hp;
        parent_index <= pidx;
        elem_row0    <= l0;
        elem_row1    <= l1;
        elem_row2    <= l2;
        elem_row3    <= l3;
        last_joint   <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    // Send one joint: four columns with random content
    task automatic send_joint(int j, logic hp, logic [JOINT_W-1:0] pidx,
                              logic last);
        logic early;
        for (int c = 0; c < 4; c++) begin
            early = (c < 3) && ($urandom_range(0, 7) == 0);
            send_request(hp, pidx, pick_elem(), pick_elem(), pick_elem(), pick_elem(),
                         (c == 3) ? last : early);
        end
    endtask

    // Send a skeleton of n joints; bad parents appear now and then
    task automatic send_skeleton(int n);
        logic hp;
        logic [JOINT_W-1:0] pidx;
        for (int j = 0; j < n; j++) begin
            hp   = (j != 0) && ($urandom_range(0, 4) != 0);
            pidx = (j == 0) ? JOINT_W'($urandom_range(0, 63))
                            : JOINT_W'($urandom_range(0, j - 1));
            if ($urandom_range(0, 39) == 0) begin
                hp   = 1'b1;
                pidx = JOINT_W'($urandom_range((j > 63) ? 63 : j, 63));
            end
            send_joint(j, hp, pidx, j == n - 1);
        end
    endtask

    // Drop valid, wait for every pending column and let the pipe drain
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(int v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LIMIT_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(v);
    endtask

    initial
    begin
        int limits [6];
        int target;
        int lim;
        sb            = new();
        requests_sent = 0;
        burst_left    = 0;
        stall_mode    = 0;
        stall_left    = 0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        has_parent    = 1'b0;
        parent_index  = '0;
        elem_row0     = '0;
        elem_row1     = '0;
        elem_row2     = '0;
        elem_row3     = '0;
        last_joint    = 1'b0;
        out_ready     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: root with extreme columns, child saturating both ways,
        // a parent that is not earlier, and a last flag on an early column.
        send_request(1'b0, 6'd63, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 0, 1'b1);
        send_request(1'b0, 6'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh0001_0000, 1'b0);
        send_request(1'b0, 6'd0, 32'sh0001_0000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_request(1'b0, 6'd0, -1, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_request(1'b1, 6'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_request(1'b1, 6'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_request(1'b1, 6'd0, -1, -1, -1, -1, 1'b0);
        send_request(1'b1, 6'd0, 32'sh0001_0000, 1, -1, 32'sh0000_8000, 1'b0);
        send_request(1'b1, 6'd2, 1, 2, 3, 4, 1'b0);
        send_request(1'b1, 6'd0, 5, 6, 7, 8, 1'b0);
        send_request(1'b0, 6'd0, 9, 10, 11, 12, 1'b0);
        send_request(1'b0, 6'd0, 13, 14, 15, 16, 1'b1);
        send_joint(0, 1'b0, 6'd0, 1'b0);
        send_joint(1, 1'b1, 6'd1, 1'b1);

        // Random phases over several joint limits, extremes included
        limits[0] = 1;
        limits[1] = 0;
        limits[2] = 127;
        limits[3] = $urandom_range(2, 6);
        limits[4] = 64;
        limits[5] = $urandom_range(1, 127);
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(limits[ph]);
            target = requests_sent + ((ph == 1) ? 60 : 170);
            lim    = (limits[ph] < JOINT_CAP) ? limits[ph] : JOINT_CAP;
            while (requests_sent < target) begin
                if ($urandom_range(0, 9) == 0) send_skeleton($urandom_range(1, lim + 2));
                else if ($urandom_range(0, 5) == 0) send_skeleton(lim);
                else send_skeleton($urandom_range(1, (lim < 8) ? ((lim < 1) ? 1 : lim) : 8));
            end
        end
        drain();

        $display("Checked %0d world columns over %0d skeletons (%0d requests).",
                 sb.checked, sb.skeletons, requests_sent);
        $display("Error columns seen: %0d parent-not-earlier, %0d over joint limit.",
                 sb.parent_errs, sb.limit_errs);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("skeleton_world_matrix_eval_tb OK");
        else
            $display("skeleton_world_matrix_eval_tb NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run
    initial
    begin
        #20ms;
        $display("skeleton_world_matrix_eval_tb NOT OK");
        $finish;
    end

endmodule

>>> skeleton_world_matrix_eval.f
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/swm_mac.sv
rtl/skeleton_world_matrix_eval.sv
tb/skeleton_world_matrix_eval_tb.sv
